// ----- rtl/ara_pkg.sv -----
// Shared types, constants and codes for the region allocator.
`timescale 1ns / 1ps
`default_nettype none
package ara_pkg;

   localparam int ARA_CELLS     = 4096;
   localparam int ARA_AW        = $clog2(ARA_CELLS);
   localparam int ARA_CNT_W     = ARA_AW + 1;
   localparam int ARA_MAX_PITCH = 64;
   localparam int ARA_CW        = 7;
   localparam int ARA_NUM_W     = 17;
   localparam int ARA_DEN_W     = 13;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic CSR_REGION_SIZE = 1'b0;
   localparam logic CSR_CELL_SIZE   = 1'b1;

   typedef enum logic [1:0] {
      ST_ALLOCATED = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_ZERO      = 2'd2,
      ST_CLEARED   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_DIV,
      S_CLEAR,
      S_SCAN,
      S_ERASE,
      S_PUSH_R,
      S_PUSH_B,
      S_CUT,
      S_DONE
   } fsm_type;

   typedef struct packed {
      logic        command;
      logic [15:0] request_width;
      logic [15:0] request_height;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ARA_AW-1:0] region_index;
      logic [ARA_CW-1:0] cells_wide;
      logic [ARA_CW-1:0] cells_high;
   } rsp_type;

   typedef struct packed {
      logic [ARA_CW-1:0] xc;
      logic [ARA_CW-1:0] yc;
   } desc_type;

endpackage
`default_nettype wire

// ----- rtl/ara_div.sv -----
// Iterative saturating divider: largest 7-bit quotient q with q * den <= num.
`timescale 1ns / 1ps
`default_nettype none
module ara_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ara_pkg::ARA_NUM_W-1:0] num,
   input  wire logic [ara_pkg::ARA_DEN_W-1:0] den,
   output logic      [ara_pkg::ARA_CW-1:0]    quot,
   output logic                               busy
);
   import ara_pkg::*;

   localparam int PW = ARA_CW + ARA_DEN_W;

   logic [ARA_NUM_W-1:0] num_ff;
   logic [ARA_DEN_W-1:0] den_ff;
   logic [ARA_CW-1:0]    quot_ff, quot_in, trial;
   logic [2:0]           bit_ff;
   logic                 busy_ff;
   logic [PW-1:0]        prod;

   always_comb begin
      trial   = quot_ff | (ARA_CW'(1) << bit_ff);
      prod    = PW'(trial) * PW'(den_ff);
      quot_in = (prod <= PW'(num_ff)) ? trial : quot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && bit_ff == 3'd0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= num;
         den_ff  <= den;
         quot_ff <= '0;
         bit_ff  <= 3'(ARA_CW - 1);
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         bit_ff  <= bit_ff - 3'd1;
      end
   end

   assign quot = quot_ff;
   assign busy = busy_ff;

endmodule
`default_nettype wire

// ----- rtl/atlas_region_allocator.sv -----
// Top level of the region allocator: free list and cell descriptors in memories.
// A clear resets the free list to the whole surface; a zero cell count skips it;
// no fit takes one pipelined scan pass, and allocate takes one scan pass and one
// erase pass over the free-list memory, one entry per cycle.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous; afterwards a built-in clear writes the whole-surface region.
`timescale 1ns / 1ps
`default_nettype none
module atlas_region_allocator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ara_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ara_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_index,
   input  wire logic [15:0]      csr_write_data
);
   import ara_pkg::*;

   fsm_type              state_ff, state_in;
   logic [15:0]          region_size_ff;
   logic [12:0]          cell_size_ff;
   logic [ARA_DEN_W-1:0] cs_eff;
   req_type              req_ff;
   logic                 init_ff;
   logic [ARA_CNT_W-1:0] fc_ff, rd_ff;
   status_type           status_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [ARA_AW-1:0]    fl_mem [ARA_CELLS];
   desc_type             desc_mem [ARA_CELLS];
   logic [ARA_AW-1:0]    fl_rd_ff;
   desc_type             desc_rd_ff;

   logic                 s1_v_ff, s2_v_ff;
   logic [ARA_CNT_W-1:0] s1_i_ff, s2_i_ff;
   logic [ARA_AW-1:0]    s2_id_ff;

   logic                 found_ff;
   logic [ARA_CNT_W-1:0] pick_i_ff;
   logic [ARA_AW-1:0]    pick_id_ff;
   desc_type             pick_d_ff;

   logic [ARA_CW-1:0]    nx, ny, qp, pitch;
   logic                 bx, by, bp, div_busy, div_start;

   logic                 issue, fl_we, desc_we, rsp_load, fits, better;
   logic [ARA_AW-1:0]    fl_waddr, fl_wdata, desc_waddr;
   desc_type             desc_wdata;
   logic [ARA_CNT_W-1:0] r_idx;
   logic [ARA_CNT_W:0]   b_idx;
   logic                 ok_r, ok_b, cnt_room;

   assign cs_eff = (cell_size_ff == '0) ? ARA_DEN_W'(1) : cell_size_ff;

   ara_div u_div_x (.clock, .reset, .start(div_start),
      .num(ARA_NUM_W'(req_ff.request_width) + ARA_NUM_W'(1)), .den(cs_eff),
      .quot(nx), .busy(bx));
   ara_div u_div_y (.clock, .reset, .start(div_start),
      .num(ARA_NUM_W'(req_ff.request_height) + ARA_NUM_W'(1)), .den(cs_eff),
      .quot(ny), .busy(by));
   ara_div u_div_p (.clock, .reset, .start(div_start),
      .num(ARA_NUM_W'(region_size_ff)), .den(cs_eff),
      .quot(qp), .busy(bp));

   assign div_busy = bx | by | bp;
   assign pitch    = (qp > ARA_CW'(ARA_MAX_PITCH)) ? ARA_CW'(ARA_MAX_PITCH) : qp;

   assign fits   = desc_rd_ff.xc >= nx && desc_rd_ff.yc >= ny;
   assign better = !found_ff || desc_rd_ff.xc < pick_d_ff.xc || desc_rd_ff.yc < pick_d_ff.yc;

   assign cnt_room = fc_ff < ARA_CNT_W'(ARA_CELLS);
   assign r_idx    = ARA_CNT_W'(pick_id_ff) + ARA_CNT_W'(nx);
   assign b_idx    = (ARA_CNT_W+1)'(pick_id_ff)
                   + (ARA_CNT_W+1)'((ARA_CNT_W+1)'(pitch) * (ARA_CNT_W+1)'(ny));
   assign ok_r     = pick_d_ff.xc > nx && r_idx < ARA_CNT_W'(ARA_CELLS) && cnt_room;
   assign ok_b     = pick_d_ff.yc > ny && b_idx < (ARA_CNT_W+1)'(ARA_CELLS) && cnt_room;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_START;
         S_START:  state_in = S_DIV;
         S_DIV: begin
            if (!div_busy) begin
               if (req_ff.command == CMD_CLEAR) state_in = S_CLEAR;
               else if (nx == '0 || ny == '0)   state_in = S_DONE;
               else                             state_in = S_SCAN;
            end
         end
         S_CLEAR:  state_in = S_DONE;
         S_SCAN: begin
            if (!issue && !s1_v_ff && !s2_v_ff) state_in = found_ff ? S_ERASE : S_DONE;
         end
         S_ERASE:  if (!issue && !s1_v_ff) state_in = S_PUSH_R;
         S_PUSH_R: state_in = S_PUSH_B;
         S_PUSH_B: state_in = S_CUT;
         S_CUT:    state_in = S_DONE;
         S_DONE:   if (init_ff || !rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      div_start  = 1'b0;
      issue      = 1'b0;
      fl_we      = 1'b0;
      fl_waddr   = '0;
      fl_wdata   = '0;
      desc_we    = 1'b0;
      desc_waddr = '0;
      desc_wdata = '{xc: pitch, yc: pitch};
      rsp_load   = 1'b0;
      case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_START: div_start = 1'b1;
         S_CLEAR: begin
            fl_we   = 1'b1;
            desc_we = 1'b1;
         end
         S_SCAN:  issue = rd_ff < fc_ff;
         S_ERASE: begin
            issue    = rd_ff < fc_ff;
            fl_we    = s1_v_ff;
            fl_waddr = ARA_AW'(s1_i_ff - ARA_CNT_W'(1));
            fl_wdata = fl_rd_ff;
         end
         S_PUSH_R: begin
            fl_we      = ok_r;
            fl_waddr   = fc_ff[ARA_AW-1:0];
            fl_wdata   = r_idx[ARA_AW-1:0];
            desc_we    = ok_r;
            desc_waddr = r_idx[ARA_AW-1:0];
            desc_wdata = '{xc: pick_d_ff.xc - nx, yc: ny};
         end
         S_PUSH_B: begin
            fl_we      = ok_b;
            fl_waddr   = fc_ff[ARA_AW-1:0];
            fl_wdata   = b_idx[ARA_AW-1:0];
            desc_we    = ok_b;
            desc_waddr = b_idx[ARA_AW-1:0];
            desc_wdata = '{xc: pick_d_ff.xc, yc: pick_d_ff.yc - ny};
         end
         S_CUT: begin
            desc_we    = 1'b1;
            desc_waddr = pick_id_ff;
            desc_wdata = '{xc: nx, yc: ny};
         end
         S_DONE:  rsp_load = !init_ff && (!rsp_valid_ff || rsp_ready);
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
      fl_rd_ff <= fl_mem[rd_ff[ARA_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (desc_we) desc_mem[desc_waddr] <= desc_wdata;
      desc_rd_ff <= desc_mem[fl_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_START;
         init_ff        <= 1'b1;
         req_ff.command <= CMD_CLEAR;
         region_size_ff <= 16'd1024;
         cell_size_ff   <= 13'd16;
         fc_ff          <= ARA_CNT_W'(1);
         s1_v_ff        <= 1'b0;
         s2_v_ff        <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_REGION_SIZE: region_size_ff <= csr_write_data;
               CSR_CELL_SIZE:   cell_size_ff   <= csr_write_data[12:0];
               default:         region_size_ff <= region_size_ff;
            endcase
         end
         if (state_ff == S_IDLE && req_valid) req_ff <= req_payload;
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff && state_ff == S_SCAN;
         if (state_ff == S_DIV) found_ff <= 1'b0;
         else if (state_ff == S_SCAN && s2_v_ff && fits && better) found_ff <= 1'b1;
         if (state_ff == S_CLEAR) fc_ff <= ARA_CNT_W'(1);
         else if (state_ff == S_ERASE && state_in == S_PUSH_R) fc_ff <= fc_ff - ARA_CNT_W'(1);
         else if ((state_ff == S_PUSH_R && ok_r) || (state_ff == S_PUSH_B && ok_b))
            fc_ff <= fc_ff + ARA_CNT_W'(1);
         if (state_ff == S_DONE && state_in == S_IDLE) init_ff <= 1'b0;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DIV) rd_ff <= '0;
      else if (state_ff == S_SCAN && state_in == S_ERASE) rd_ff <= pick_i_ff + ARA_CNT_W'(1);
      else if (issue) rd_ff <= rd_ff + ARA_CNT_W'(1);
      s1_i_ff  <= rd_ff;
      s2_i_ff  <= s1_i_ff;
      s2_id_ff <= fl_rd_ff;
      if (state_ff == S_SCAN && s2_v_ff && fits && better) begin
         pick_i_ff  <= s2_i_ff;
         pick_id_ff <= s2_id_ff;
         pick_d_ff  <= desc_rd_ff;
      end
      case (state_ff)
         S_DIV: begin
            if (req_ff.command == CMD_CLEAR) status_ff <= ST_CLEARED;
            else if (nx == '0 || ny == '0)   status_ff <= ST_ZERO;
            else                             status_ff <= ST_NO_FIT;
         end
         S_CUT:   status_ff <= ST_ALLOCATED;
         default: status_ff <= status_ff;
      endcase
      if (rsp_load) begin
         rsp_ff.status <= status_ff;
         if (status_ff == ST_ALLOCATED) begin
            rsp_ff.region_index <= pick_id_ff;
            rsp_ff.cells_wide   <= nx;
            rsp_ff.cells_high   <= ny;
         end else begin
            rsp_ff.region_index <= '0;
            rsp_ff.cells_wide   <= '0;
            rsp_ff.cells_high   <= '0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= ARA_CNT_W'(ARA_CELLS))
      else $error("free count beyond capacity");

   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERASE) |-> (found_ff && pick_d_ff.xc >= nx && pick_d_ff.yc >= ny))
      else $error("erasing a region that does not fit");

   a_scan_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (nx != '0 && ny != '0 && !div_busy))
      else $error("scan with zero cell count or busy divider");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (state_ff == S_DONE && !init_ff))
      else $error("result loaded outside completion");

endmodule
`default_nettype wire

// ----- tb/sv/atlas_region_allocator_checker.sv -----
// Checker for the region allocator: predicts results and compares them.
`timescale 1ns / 1ps
module atlas_region_allocator_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire ara_pkg::req_type req_payload,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire ara_pkg::rsp_type rsp_payload,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_index,
   input  wire logic [15:0]      csr_write_data,
   output int                    error_count,
   output int                    pending_count
);
   import ara_pkg::*;

   logic [15:0]       surface_px;
   logic [12:0]       cell_px;
   logic [11:0]       free_cells [ARA_CELLS];
   int                free_total;
   logic [6:0]        desc_w [ARA_CELLS];
   logic [6:0]        desc_h [ARA_CELLS];
   rsp_type           expected_rsp [$];

   function automatic int pitch_now();
      int cs;
      int p;
      cs = (cell_px == 0) ? 1 : cell_px;
      p = surface_px / cs;
      return (p > ARA_MAX_PITCH) ? ARA_MAX_PITCH : p;
   endfunction

   function automatic void whole_surface();
      int p;
      p = pitch_now();
      free_cells[0] = 0;
      free_total = 1;
      desc_w[0] = p[6:0];
      desc_h[0] = p[6:0];
   endfunction

   function automatic void add_leftover(int idx, int xc, int yc);
      if (idx >= ARA_CELLS || free_total >= ARA_CELLS) return;
      desc_w[idx] = xc[6:0];
      desc_h[idx] = yc[6:0];
      free_cells[free_total] = idx[11:0];
      free_total++;
   endfunction

   function automatic rsp_type allocate(req_type r);
      rsp_type o;
      int cs, nx, ny, pick, id, ox, oy;
      bit found;
      o = '0;
      found = 0;
      pick = 0;
      if (r.command == CMD_CLEAR) begin
         whole_surface();
         o.status = ST_CLEARED;
         return o;
      end
      cs = (cell_px == 0) ? 1 : cell_px;
      nx = (int'(r.request_width) + 1) / cs;
      ny = (int'(r.request_height) + 1) / cs;
      if (nx == 0 || ny == 0) begin
         o.status = ST_ZERO;
         return o;
      end
      for (int i = 0; i < free_total; i++) begin
         int d;
         d = free_cells[i];
         if (desc_w[d] >= nx && desc_h[d] >= ny) begin
            if (!found) begin
               pick = i;
               found = 1;
            end else if (desc_w[d] < desc_w[free_cells[pick]] ||
                         desc_h[d] < desc_h[free_cells[pick]]) begin
               pick = i;
            end
         end
      end
      if (!found) begin
         o.status = ST_NO_FIT;
         return o;
      end
      id = free_cells[pick];
      for (int i = pick; i + 1 < free_total; i++) free_cells[i] = free_cells[i + 1];
      free_total--;
      ox = desc_w[id];
      oy = desc_h[id];
      if (ox > nx || oy > ny) begin
         if (ox > nx) add_leftover(id + nx, ox - nx, ny);
         if (oy > ny) add_leftover(id + pitch_now() * ny, ox, oy - ny);
         desc_w[id] = nx[6:0];
         desc_h[id] = ny[6:0];
      end
      o.status = ST_ALLOCATED;
      o.region_index = id[11:0];
      o.cells_wide = desc_w[id];
      o.cells_high = desc_h[id];
      return o;
   endfunction

   assign pending_count = expected_rsp.size();

   always @(posedge clock) begin
      if (reset) begin
         surface_px <= 16'd1024;
         cell_px <= 13'd16;
         expected_rsp.delete();
         error_count <= 0;
         free_cells[0] = 0;
         free_total = 1;
         desc_w[0] = 7'd64;
         desc_h[0] = 7'd64;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_REGION_SIZE) surface_px <= csr_write_data;
            else cell_px <= csr_write_data[12:0];
         end
         if (req_valid && req_ready)
            expected_rsp.insert(expected_rsp.size(), allocate(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_payload);
               error_count <= error_count + 1;
            end else begin
               rsp_type e;
               e = expected_rsp.pop_front();
               if (e.status != rsp_payload.status ||
                   e.region_index != rsp_payload.region_index ||
                   e.cells_wide != rsp_payload.cells_wide ||
                   e.cells_high != rsp_payload.cells_high) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_payload);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- tb/sv/atlas_region_allocator_tb.sv -----
// Testbench top for the region allocator: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module atlas_region_allocator_tb;
   import ara_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_payload;
   logic    csr_write_enable = 0;
   logic    csr_index = 0;
   logic [15:0] csr_write_data = 0;
   int      error_count;
   int      pending_count;
   int      request_total = 0;
   bit      busy_phase = 0;

   always #10 clock = ~clock;

   atlas_region_allocator dut (.*);
   atlas_region_allocator_checker chk (.*);

   always @(posedge clock) begin
      if (busy_phase) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 20);
   end

   task automatic send(logic cmd, logic [15:0] w, logic [15:0] h);
      req_type r;
      r.command = cmd;
      r.request_width = w;
      r.request_height = h;
      do @(posedge clock);
      while (!busy_phase && $urandom_range(99) < 20);
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_valid <= 1'b0;
      request_total++;
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_alloc(int unit_px);
      int maxc;
      maxc = 10;
      send(CMD_ALLOC, 16'(unit_px * $urandom_range(maxc) + $urandom_range(unit_px - 1)),
           16'(unit_px * $urandom_range(maxc) + $urandom_range(unit_px - 1)));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(CMD_ALLOC, 16'd0, 16'd0);
      send(CMD_ALLOC, 16'd14, 16'd100);
      send(CMD_ALLOC, 16'd15, 16'd15);
      send(CMD_ALLOC, 16'd100, 16'd15);
      send(CMD_ALLOC, 16'hFFFF, 16'hFFFF);
      send(CMD_ALLOC, 16'd1023, 16'd1023);
      send(CMD_ALLOC, 16'd47, 16'd31);
      send(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
      send(CMD_ALLOC, 16'd1023, 16'd1023);
      send(CMD_ALLOC, 16'd15, 16'd15);
      send(CMD_CLEAR, 16'h5555, 16'hAAAA);
      write_reg(CSR_CELL_SIZE, 16'd0);
      write_reg(CSR_REGION_SIZE, 16'd3);
      send(CMD_ALLOC, 16'd0, 16'd0);
      send(CMD_CLEAR, 16'd0, 16'd0);
      send(CMD_ALLOC, 16'd0, 16'd0);
      send(CMD_ALLOC, 16'd1, 16'd0);
      send(CMD_ALLOC, 16'd0, 16'd2);
      write_reg(CSR_REGION_SIZE, 16'hFFFF);
      write_reg(CSR_CELL_SIZE, 16'd4096);
      send(CMD_CLEAR, 16'd0, 16'd0);
      send(CMD_ALLOC, 16'd4095, 16'd4095);
      send(CMD_ALLOC, 16'd4095, 16'd4095);
      write_reg(CSR_CELL_SIZE, 16'h1FFF);
      send(CMD_CLEAR, 16'd0, 16'd0);
      write_reg(CSR_CELL_SIZE, 16'd1);
      write_reg(CSR_REGION_SIZE, 16'd8);
      send(CMD_CLEAR, 16'd0, 16'd0);
      send(CMD_ALLOC, 16'd2, 16'd4);
      send(CMD_ALLOC, 16'd0, 16'd0);
      for (int phase = 0; phase < 4; phase++) begin
         int unit_px;
         case (phase)
            0: begin write_reg(CSR_REGION_SIZE, 16'd1024); write_reg(CSR_CELL_SIZE, 16'd16); end
            1: begin write_reg(CSR_REGION_SIZE, 16'd200); write_reg(CSR_CELL_SIZE, 16'd20); end
            2: begin write_reg(CSR_REGION_SIZE, 16'd65535); write_reg(CSR_CELL_SIZE, 16'd1); end
            default: begin write_reg(CSR_REGION_SIZE, 16'd500); write_reg(CSR_CELL_SIZE, 16'd7); end
         endcase
         unit_px = (phase == 0) ? 16 : (phase == 1) ? 20 : (phase == 2) ? 1 : 7;
         busy_phase = (phase == 2);
         send(CMD_CLEAR, 16'($urandom), 16'($urandom));
         for (int i = 0; i < 18; i++) begin
            int k;
            k = $urandom_range(99);
            if (k < 5) send(CMD_CLEAR, 16'($urandom), 16'($urandom));
            else if (k < 12) send(CMD_ALLOC, 16'($urandom), 16'($urandom));
            else random_alloc(unit_px);
         end
         busy_phase = 0;
      end
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d requests over several surface and cell sizes", request_total);
      $display("including clears, zero counts, no-fit and clamped pitch cases");
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #40ms;
      $display("tb: failure");
      $finish;
   end
endmodule

// ----- atlas_region_allocator.f -----
rtl/ara_pkg.sv
rtl/ara_div.sv
rtl/atlas_region_allocator.sv
tb/sv/atlas_region_allocator_checker.sv
tb/sv/atlas_region_allocator_tb.sv
